@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/slqa_pkg.sv @@
// shared types and constants for the settled load qualifier averager
package slqa_pkg;

    localparam int LOAD_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int SPEED_W   = 16;
    localparam int DELTA_W   = 16;
    localparam int ETL_W     = 18;
    localparam int MINQ_W    = 16;
    localparam int FIELD_W   = 16;
    localparam int FRAC_SHIFT = 12;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;

    localparam int NUM_CORNERS = 4;

    // register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_MAX_LIN   = 3'd0;
    localparam logic [2:0] REG_MAX_ANG   = 3'd1;
    localparam logic [2:0] REG_DELTA     = 3'd2;
    localparam logic [2:0] REG_EXP_TOTAL = 3'd3;
    localparam logic [2:0] REG_MIN_QUAL  = 3'd4;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/slqa_div.sv @@
// shared restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module slqa_div #(
    parameter int LOAD_BITS  = slqa_pkg::LOAD_BITS_DEF,
    parameter int COUNT_BITS = slqa_pkg::COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [LOAD_BITS+COUNT_BITS-1:0] dividend,
    input  logic [COUNT_BITS-1:0]           divisor,
    output logic [LOAD_BITS-1:0]            quotient,
    output slqa_pkg::div_status_t           status
);

    localparam int SUM_W = LOAD_BITS + COUNT_BITS;
    localparam int CNT_W = $clog2(LOAD_BITS + 1);

    typedef enum logic {
        DV_IDLE,
        DV_RUN
    } dv_state_t;

    dv_state_t             state_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [LOAD_BITS-1:0]  quo_reg;
    logic [COUNT_BITS-1:0] div_reg;

    logic [COUNT_BITS:0]   trial_c;
    logic [COUNT_BITS:0]   diff_c;
    logic                  ge_c;

    // quotient fits in LOAD_BITS, so the top bits of the sum start as remainder
    assign trial_c = {rem_reg, quo_reg[LOAD_BITS-1]};
    assign diff_c  = trial_c - {1'b0, div_reg};
    assign ge_c    = trial_c >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                DV_IDLE: begin
                    if (start) begin
                        rem_reg   <= dividend[SUM_W-1:LOAD_BITS];
                        quo_reg   <= dividend[LOAD_BITS-1:0];
                        div_reg   <= divisor;
                        cnt_reg   <= '0;
                        state_reg <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    rem_reg <= ge_c ? diff_c[COUNT_BITS-1:0] : trial_c[COUNT_BITS-1:0];
                    quo_reg <= {quo_reg[LOAD_BITS-2:0], ge_c};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(LOAD_BITS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= DV_IDLE;
                    end
                end
                default: begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = (state_reg == DV_RUN);
    assign status.done = done_reg;

    `ASSERT_NEXT(a_start_runs, aclk, aresetn, start, status.busy, "divider did not start")
    `ASSERT_IMPLIES(a_done_idle, aclk, aresetn, done_reg, !status.busy, "done while running")

endmodule

@@ rtl/settled_load_qualifier_averager.sv @@
// settled load qualifier averager top level: sequencer, state and config registers
//
//  channel  | direction | contents
//  s_       | in        | tuser: opcode; tdata: speeds and four corner loads
//  m_       | out       | tuser: accepted, mean_valid; tdata: count and four means
//  apb      | in/out    | five config registers at byte addresses 0,4,8,12,16
//
// a push with valid means goes from accept through eval, update and check, then the shared
// divider, doing one quotient bit per cycle, runs once for each of the four corners before done;
// a clear or a sample without valid means goes from check straight to done
// s_tready is high only while the sequencer is idle; a held result on m_ can block it
// a finished result waits in its state only until the output register is free
// reset is synchronous, active low, and clears state and config to their defaults
`include "assert_macros.svh"

module settled_load_qualifier_averager #(
    parameter int LOAD_BITS  = slqa_pkg::LOAD_BITS_DEF,
    parameter int COUNT_BITS = slqa_pkg::COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [slqa_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [slqa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [slqa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // linear_speed, angular_speed, load_front_left, load_front_right,
    // load_rear_left, load_rear_right
    input  logic [slqa_pkg::IN_TDATA_W-1:0]     s_tdata,
    // opcode
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // qualified_count, mean_front_left, mean_front_right, mean_rear_left, mean_rear_right
    output logic [slqa_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // accepted, mean_valid
    output logic [slqa_pkg::OUT_TUSER_W-1:0]    m_tuser
);

    localparam int SUM_W  = LOAD_BITS + COUNT_BITS;
    localparam int PROD_W = slqa_pkg::DELTA_W + slqa_pkg::ETL_W;
    localparam int ALW_W  = PROD_W - slqa_pkg::FRAC_SHIFT;
    localparam int DIFF_W = (ALW_W > LOAD_BITS) ? ALW_W : LOAD_BITS;
    localparam int CMP_W  = (COUNT_BITS > slqa_pkg::MINQ_W) ? COUNT_BITS : slqa_pkg::MINQ_W;
    localparam int FW     = slqa_pkg::FIELD_W;
    localparam int NC     = slqa_pkg::NUM_CORNERS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_UPDATE,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    // config registers
    logic [slqa_pkg::SPEED_W-1:0] max_lin_reg;
    logic [slqa_pkg::SPEED_W-1:0] max_ang_reg;
    logic [slqa_pkg::DELTA_W-1:0] delta_reg;
    logic [slqa_pkg::ETL_W-1:0]   exp_total_reg;
    logic [slqa_pkg::MINQ_W-1:0]  min_qual_reg;

    state_t                       state_reg;

    // captured word
    logic                         op_reg;
    logic [slqa_pkg::SPEED_W-1:0] lin_reg;
    logic [slqa_pkg::SPEED_W-1:0] ang_reg;
    logic [LOAD_BITS-1:0]         load_in_reg [NC];

    // running state
    logic                         have_prev_reg;
    logic [LOAD_BITS-1:0]         prev_reg [NC];
    logic [COUNT_BITS-1:0]        count_reg;
    logic [SUM_W-1:0]             sum_reg [NC];

    // evaluation and result
    logic                         spd_ok_reg;
    logic [ALW_W-1:0]             allowed_reg;
    logic [LOAD_BITS-1:0]         worst_reg;
    logic                         accepted_reg;
    logic                         valid_reg;
    logic [LOAD_BITS-1:0]         mean_reg [NC];
    logic [1:0]                   corner_reg;

    logic                         m_tvalid_reg;
    logic [slqa_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [slqa_pkg::OUT_TUSER_W-1:0] m_tuser_reg;

    logic                         cfg_wr_c;
    logic                         cfg_ok_c;
    logic                         accept_c;
    logic [PROD_W-1:0]            prod_c;
    logic [LOAD_BITS-1:0]         diff_c [NC];
    logic [LOAD_BITS-1:0]         w01_c;
    logic [LOAD_BITS-1:0]         w23_c;
    logic [LOAD_BITS-1:0]         worst_c;

    logic                         div_start;
    logic [LOAD_BITS-1:0]         div_quo;
    slqa_pkg::div_status_t        div_stat;

    // config port
    assign pready   = 1'b1;
    assign cfg_wr_c = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_lin_reg   <= '0;
            max_ang_reg   <= '0;
            delta_reg     <= '0;
            exp_total_reg <= slqa_pkg::ETL_W'(1);
            min_qual_reg  <= slqa_pkg::MINQ_W'(1);
        end else if (cfg_wr_c) begin
            case (paddr[4:2])
                slqa_pkg::REG_MAX_LIN:   max_lin_reg   <= pwdata[slqa_pkg::SPEED_W-1:0];
                slqa_pkg::REG_MAX_ANG:   max_ang_reg   <= pwdata[slqa_pkg::SPEED_W-1:0];
                slqa_pkg::REG_DELTA:     delta_reg     <= pwdata[slqa_pkg::DELTA_W-1:0];
                slqa_pkg::REG_EXP_TOTAL: exp_total_reg <= pwdata[slqa_pkg::ETL_W-1:0];
                slqa_pkg::REG_MIN_QUAL:  min_qual_reg  <= pwdata[slqa_pkg::MINQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            slqa_pkg::REG_MAX_LIN:   prdata = slqa_pkg::APB_DATA_W'(max_lin_reg);
            slqa_pkg::REG_MAX_ANG:   prdata = slqa_pkg::APB_DATA_W'(max_ang_reg);
            slqa_pkg::REG_DELTA:     prdata = slqa_pkg::APB_DATA_W'(delta_reg);
            slqa_pkg::REG_EXP_TOTAL: prdata = slqa_pkg::APB_DATA_W'(exp_total_reg);
            slqa_pkg::REG_MIN_QUAL:  prdata = slqa_pkg::APB_DATA_W'(min_qual_reg);
            default:                 prdata = '0;
        endcase
    end

    // qualification datapath
    assign cfg_ok_c = (min_qual_reg != '0) && (exp_total_reg != '0);
    assign prod_c   = PROD_W'(delta_reg) * PROD_W'(exp_total_reg);

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            diff_c[i] = (load_in_reg[i] > prev_reg[i]) ? load_in_reg[i] - prev_reg[i]
                                                       : prev_reg[i] - load_in_reg[i];
        end
    end

    assign w01_c   = (diff_c[0] > diff_c[1]) ? diff_c[0] : diff_c[1];
    assign w23_c   = (diff_c[2] > diff_c[3]) ? diff_c[2] : diff_c[3];
    assign worst_c = (w01_c > w23_c) ? w01_c : w23_c;

    assign accept_c = spd_ok_reg && cfg_ok_c &&
                      !(have_prev_reg && (DIFF_W'(worst_reg) > DIFF_W'(allowed_reg)));

    assign div_start = (state_reg == ST_DIV_GO);

    slqa_div #(
        .LOAD_BITS  (LOAD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg[corner_reg]),
        .divisor  (count_reg),
        .quotient (div_quo),
        .status   (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            corner_reg    <= '0;
            for (int i = 0; i < NC; i++) begin
                prev_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end else begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg         <= s_tuser[0];
                        lin_reg        <= s_tdata[FW-1:0];
                        ang_reg        <= s_tdata[2*FW-1:FW];
                        load_in_reg[0] <= LOAD_BITS'(s_tdata[3*FW-1:2*FW]);
                        load_in_reg[1] <= LOAD_BITS'(s_tdata[4*FW-1:3*FW]);
                        load_in_reg[2] <= LOAD_BITS'(s_tdata[5*FW-1:4*FW]);
                        load_in_reg[3] <= LOAD_BITS'(s_tdata[6*FW-1:5*FW]);
                        state_reg      <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    spd_ok_reg  <= (lin_reg <= max_lin_reg) && (ang_reg <= max_ang_reg);
                    allowed_reg <= prod_c[PROD_W-1:slqa_pkg::FRAC_SHIFT];
                    worst_reg   <= worst_c;
                    state_reg   <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (op_reg == slqa_pkg::OP_CLEAR || !accept_c) begin
                        accepted_reg  <= 1'b0;
                        have_prev_reg <= 1'b0;
                        count_reg     <= '0;
                        for (int i = 0; i < NC; i++) begin
                            prev_reg[i] <= '0;
                            sum_reg[i]  <= '0;
                        end
                    end else begin
                        accepted_reg  <= 1'b1;
                        have_prev_reg <= 1'b1;
                        for (int i = 0; i < NC; i++) begin
                            prev_reg[i] <= load_in_reg[i];
                        end
                        if (count_reg != '1) begin
                            count_reg <= count_reg + 1'b1;
                            for (int i = 0; i < NC; i++) begin
                                sum_reg[i] <= sum_reg[i] + SUM_W'(load_in_reg[i]);
                            end
                        end
                    end
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    valid_reg  <= cfg_ok_c && (count_reg != '0) &&
                                  (CMP_W'(count_reg) >= CMP_W'(min_qual_reg));
                    corner_reg <= '0;
                    for (int i = 0; i < NC; i++) begin
                        mean_reg[i] <= '0;
                    end
                    if (cfg_ok_c && (count_reg != '0) &&
                        (CMP_W'(count_reg) >= CMP_W'(min_qual_reg))) begin
                        state_reg <= ST_DIV_GO;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_stat.done) begin
                        mean_reg[corner_reg] <= div_quo;
                        corner_reg           <= corner_reg + 1'b1;
                        if (corner_reg == 2'(NC - 1)) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= {valid_reg, accepted_reg};
                        m_tdata_reg  <= {FW'(mean_reg[3]), FW'(mean_reg[2]),
                                         FW'(mean_reg[1]), FW'(mean_reg[0]),
                                         FW'(count_reg)};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_IMPLIES(a_done_in_wait, aclk, aresetn, div_stat.done, state_reg == ST_DIV_WAIT, "divider done outside wait")
    `ASSERT_IMPLIES(a_start_idle, aclk, aresetn, div_start, !div_stat.busy, "divider started while busy")
    `ASSERT_IMPLIES(a_count_needs_prev, aclk, aresetn, !have_prev_reg, count_reg == '0, "count without previous word")

endmodule
